@@ rtl/xrd_pkg.sv @@
`default_nettype none
package xrd_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int NUM_NAMES  = 5;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;

    typedef enum logic [2:0] {
        NM_LT   = 3'd0,
        NM_GT   = 3'd1,
        NM_AMP  = 3'd2,
        NM_QUOT = 3'd3,
        NM_APOS = 3'd4
    } t_name;

    typedef struct packed {
        logic        ok;
        logic [20:0] cp;
        logic [2:0]  nb;
    } t_acc_stat;

    function automatic logic [7:0] name_char(input logic [2:0] id, input logic [1:0] pos);
        logic [31:0] s;
        begin
            unique case (id)
                NM_LT:   s = 32'h0000746C;
                NM_GT:   s = 32'h00007467;
                NM_AMP:  s = 32'h00706D61;
                NM_QUOT: s = 32'h746F7571;
                NM_APOS: s = 32'h736F7061;
                default: s = 32'h0;
            endcase
            name_char = s[{pos, 3'b000} +: 8];
        end
    endfunction

    function automatic logic [2:0] name_len(input logic [2:0] id);
        begin
            unique case (id)
                NM_LT, NM_GT:    name_len = 3'd2;
                NM_AMP:          name_len = 3'd3;
                NM_QUOT, NM_APOS: name_len = 3'd4;
                default:         name_len = 3'd0;
            endcase
        end
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        begin
            if (cp < 21'h80) begin
                utf8_len = 3'd1;
            end else if (cp < 21'h800) begin
                utf8_len = 3'd2;
            end else if (cp < 21'h10000) begin
                utf8_len = 3'd3;
            end else begin
                utf8_len = 3'd4;
            end
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] nb,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] sh;
        begin
            sh = 2'(nb - 3'd1 - {1'b0, idx});
            b = 8'h80 | {2'b00, cp[{sh, 1'b0} * 3 +: 6]};
            if (idx == 2'd0) begin
                case (nb)
                    3'd1: b = cp[7:0];
                    3'd2: b = 8'hC0 | {3'b000, cp[10:6]};
                    3'd3: b = 8'hE0 | {4'b0000, cp[15:12]};
                    default: b = 8'hF0 | {5'b00000, cp[20:18]};
                endcase
            end
            utf8_byte = b;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/xrd_ref_acc.sv @@
`default_nettype none
module xrd_ref_acc
    import xrd_pkg::*;
#(
    parameter int AW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic [AW-1:0] i_k,
    input  wire logic [AW-1:0] i_count,
    output t_acc_stat          o_stat
);

    logic                 r_num;
    logic                 r_hex;
    logic                 r_bad;
    logic                 r_ndig;
    logic [20:0]          r_cp;
    logic [NUM_NAMES-1:0] r_m;

    logic        w_isdig;
    logic [3:0]  w_d;
    logic [24:0] n_cp;

    always_comb begin
        w_isdig = 1'b1;
        w_d     = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_d = 4'(i_byte - 8'h30);
        end else if (r_hex && i_byte >= 8'h61 && i_byte <= 8'h66) begin
            w_d = 4'(i_byte - 8'h57);
        end else if (r_hex && i_byte >= 8'h41 && i_byte <= 8'h46) begin
            w_d = 4'(i_byte - 8'h37);
        end else begin
            w_isdig = 1'b0;
        end
        n_cp = (r_hex ? {r_cp, 4'b0000} : 25'(r_cp) * 25'd10) + 25'(w_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (i_k == '0) begin
                r_num  <= (i_byte == CH_HASH);
                r_hex  <= 1'b0;
                r_bad  <= 1'b0;
                r_ndig <= 1'b0;
                r_cp   <= '0;
                for (int i = 0; i < NUM_NAMES; i++) begin
                    r_m[i] <= (i_byte == name_char(3'(i), 2'd0));
                end
            end else begin
                for (int i = 0; i < NUM_NAMES; i++) begin
                    r_m[i] <= r_m[i] && (i_k < AW'(name_len(3'(i))))
                              && (i_byte == name_char(3'(i), i_k[1:0]));
                end
                if (i_k == AW'(1) && i_byte == CH_X) begin
                    r_hex <= 1'b1;
                end else if (!r_bad) begin
                    if (!w_isdig || n_cp > 25'(CP_MAX)) begin
                        r_bad <= 1'b1;
                    end else begin
                        r_cp   <= n_cp[20:0];
                        r_ndig <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_stat.ok = 1'b0;
        o_stat.cp = '0;
        if (r_num) begin
            o_stat.ok = !r_bad && r_ndig && r_cp != '0
                        && !(r_cp >= CP_SUR_LO && r_cp <= CP_SUR_HI);
            o_stat.cp = r_cp;
        end else begin
            for (int i = 0; i < NUM_NAMES; i++) begin
                if (r_m[i] && i_count == AW'(name_len(3'(i)))) begin
                    o_stat.ok = 1'b1;
                    unique case (3'(i))
                        NM_LT:   o_stat.cp = 21'(CH_LT);
                        NM_GT:   o_stat.cp = 21'(CH_GT);
                        NM_AMP:  o_stat.cp = 21'(CH_AMP);
                        NM_QUOT: o_stat.cp = 21'(CH_QUOT);
                        default: o_stat.cp = 21'(CH_APOS);
                    endcase
                end
            end
        end
        o_stat.nb = utf8_len(o_stat.cp);
    end

endmodule
`default_nettype wire

@@ rtl/xml_reference_decoder.sv @@
// Flow: a plain byte passes the fetch, feed and emit states into a hold register and
// moves to the output register when the next byte is emitted or the transaction ends;
// a reference is decoded one buffered byte at a time, then emitted byte by byte.
// Only one transaction is taken at a time; a failed reference replays up to WINDOW
// buffered bytes through one read port. Output stalls hold the sequencer.
// Reset: synchronous, active low; clears the sequencer, pointers and output valid.
`default_nettype none
module xml_reference_decoder
    import xrd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic       s_axis_tlast,   // in_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_byte
    output logic            m_axis_tlast,   // out_last
    output logic            m_axis_tuser    // out_string_end
);

    localparam int AW    = $clog2(WINDOW + 2);
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_FEED, S_DREAD, S_DSTEP, S_DEVAL, S_EMIT, S_FINISH
    } t_state;

    t_state          r_state;
    logic [7:0]      r_mem [DEPTH];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   r_s;
    logic [AW-1:0]   r_rd;
    logic [AW-1:0]   r_len;
    logic [AW-1:0]   r_k;
    logic [AW-1:0]   r_pc;
    logic            r_coll;
    logic            r_end;
    logic [20:0]     r_cp;
    logic [2:0]      r_nb;
    logic [1:0]      r_idx;
    logic            r_hold_v;
    logic [7:0]      r_hold;
    logic            r_ov;
    logic [7:0]      r_ob;
    logic            r_olast;
    logic            r_oend;

    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_pc;
    logic            w_push_ok;
    logic            w_load;
    logic [7:0]      w_ebyte;
    t_acc_stat       w_stat;

    assign w_pc      = r_rd - r_s;
    assign w_push_ok = !r_ov || m_axis_tready;
    assign w_load    = (r_state == S_EMIT || r_state == S_FINISH) && r_hold_v && w_push_ok;
    assign w_ebyte   = utf8_byte(r_cp, r_nb, r_idx);
    assign w_raddr   = (r_state == S_DREAD) ? r_s + r_k : r_rd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ob;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oend;

    xrd_ref_acc #(.AW(AW)) u_acc (
        .i_clk   (i_clk),
        .i_step  (r_state == S_DSTEP),
        .i_byte  (r_rdata),
        .i_k     (r_k),
        .i_count (r_pc),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_mem[r_len] <= s_axis_tdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s      <= '0;
            r_rd     <= '0;
            r_len    <= '0;
            r_coll   <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
            r_end    <= 1'b0;
            r_k      <= '0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_len   <= r_len + AW'(1);
                        r_end   <= s_axis_tlast;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_idx <= 2'd0;
                    r_nb  <= 3'd1;
                    if (r_rd != r_len) begin
                        r_state <= S_FEED;
                    end else if (r_end && r_coll) begin
                        r_cp    <= 21'(CH_AMP);
                        r_rd    <= r_s;
                        r_coll  <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FEED: begin
                    if (!r_coll) begin
                        r_rd <= r_rd + AW'(1);
                        if (r_rdata == CH_AMP) begin
                            r_coll  <= 1'b1;
                            r_s     <= r_rd + AW'(1);
                            r_state <= S_FETCH;
                        end else begin
                            r_cp    <= 21'(r_rdata);
                            r_state <= S_EMIT;
                        end
                    end else if (r_rdata == CH_SEMI) begin
                        r_pc <= w_pc;
                        r_k  <= '0;
                        if (w_pc == '0) begin
                            r_cp    <= 21'(CH_AMP);
                            r_rd    <= r_s;
                            r_coll  <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DREAD;
                        end
                    end else if ({1'b0, w_pc} + (AW+1)'(1) >= (AW+1)'(WINDOW)) begin
                        r_cp    <= 21'(CH_AMP);
                        r_rd    <= r_s;
                        r_coll  <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_rd    <= r_rd + AW'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_DREAD: begin
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    r_k     <= r_k + AW'(1);
                    r_state <= (r_k + AW'(1) == r_pc) ? S_DEVAL : S_DREAD;
                end
                S_DEVAL: begin
                    r_coll <= 1'b0;
                    if (w_stat.ok) begin
                        r_cp <= w_stat.cp;
                        r_nb <= w_stat.nb;
                        r_rd <= r_rd + AW'(1);
                    end else begin
                        r_cp <= 21'(CH_AMP);
                        r_nb <= 3'd1;
                        r_rd <= r_s;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_hold_v || w_push_ok) begin
                        if (r_hold_v) begin
                            r_ob    <= r_hold;
                            r_olast <= 1'b0;
                            r_oend  <= 1'b0;
                        end
                        r_hold_v <= 1'b1;
                        r_hold   <= w_ebyte;
                        r_idx    <= r_idx + 2'd1;
                        if (3'(r_idx) + 3'd1 == r_nb) begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (w_push_ok) begin
                        r_ob     <= r_hold;
                        r_olast  <= 1'b1;
                        r_oend   <= r_end;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/xrd_checker.sv @@
`default_nettype none
module xrd_props (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("string end without last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after a transaction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear the handshakes");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind xml_reference_decoder xrd_props u_xrd_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ test/xrd_checker.sv @@
module xrd_checker
    import xrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_data,
    input  wire logic       s_last,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_data,
    input  wire logic       m_last,
    input  wire logic       m_user,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = WINDOW_DEF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       str_end;
    } t_out_byte;

    t_out_byte  decoded_q[$];
    bit         in_ref;
    logic [7:0] name_buf[WIN];
    int         name_len_r;
    logic [7:0] replay_q[$];
    t_out_byte  step_out[$];

    function automatic void put_byte(input logic [7:0] b);
        t_out_byte r;
        r.data = b;
        r.last = 1'b0;
        r.str_end = 1'b0;
        step_out = {step_out, r};
    endfunction

    function automatic void put_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_byte(8'hC0 | 8'(cp >> 6));
            put_byte(8'h80 | 8'(cp & 21'h3F));
        end else if (cp < 21'h10000) begin
            put_byte(8'hE0 | 8'(cp >> 12));
            put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
            put_byte(8'h80 | 8'(cp & 21'h3F));
        end else begin
            put_byte(8'hF0 | 8'(cp >> 18));
            put_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
            put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
            put_byte(8'h80 | 8'(cp & 21'h3F));
        end
    endfunction

    function automatic bit name_match(input string s);
        if (name_len_r != s.len()) return 0;
        for (int i = 0; i < s.len(); i++) begin
            if (name_buf[i] != s[i]) return 0;
        end
        return 1;
    endfunction

    function automatic bit resolve_ref();
        bit      hex;
        int      k;
        logic [31:0] cp;
        logic [7:0]  c;
        logic [31:0] d;
        if (name_len_r == 0) return 0;
        if (name_buf[0] == CH_HASH) begin
            hex = name_len_r > 1 && name_buf[1] == CH_X;
            k = hex ? 2 : 1;
            cp = 0;
            if (k >= name_len_r) return 0;
            for (; k < name_len_r; k++) begin
                c = name_buf[k];
                if (c >= "0" && c <= "9") d = c - "0";
                else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
                else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
                else return 0;
                cp = cp * (hex ? 16 : 10) + d;
                if (cp > 32'h10FFFF) return 0;
            end
            if (cp == 0 || (cp >= 32'hD800 && cp <= 32'hDFFF)) return 0;
            put_utf8(cp[20:0]);
            return 1;
        end
        if (name_match("lt")) begin put_byte(CH_LT); return 1; end
        if (name_match("gt")) begin put_byte(CH_GT); return 1; end
        if (name_match("amp")) begin put_byte(CH_AMP); return 1; end
        if (name_match("quot")) begin put_byte(CH_QUOT); return 1; end
        if (name_match("apos")) begin put_byte(CH_APOS); return 1; end
        return 0;
    endfunction

    function automatic void abandon_ref(input bit with_extra, input logic [7:0] extra);
        logic [7:0] tmp[$];
        put_byte(CH_AMP);
        for (int i = 0; i < name_len_r; i++) tmp = {tmp, name_buf[i]};
        if (with_extra) tmp = {tmp, extra};
        replay_q = {tmp, replay_q};
        in_ref = 0;
        name_len_r = 0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        if (!in_ref) begin
            if (b == CH_AMP) begin
                in_ref = 1;
                name_len_r = 0;
            end else begin
                put_byte(b);
            end
        end else if (b == CH_SEMI) begin
            if (resolve_ref()) begin
                in_ref = 0;
                name_len_r = 0;
            end else begin
                abandon_ref(1, b);
            end
        end else if (name_len_r + 1 >= WIN) begin
            abandon_ref(1, b);
        end else begin
            name_buf[name_len_r] = b;
            name_len_r++;
        end
    endfunction

    function automatic void decode_item(input logic [7:0] b, input logic str_end);
        step_out.delete();
        replay_q.delete();
        replay_q = {replay_q, b};
        forever begin
            while (replay_q.size() > 0) scan_byte(replay_q.pop_front());
            if (str_end && in_ref) abandon_ref(0, 8'h00);
            else break;
        end
        if (step_out.size() > 0) begin
            step_out[$].last = 1'b1;
            step_out[$].str_end = str_end;
        end
        foreach (step_out[i]) decoded_q = {decoded_q, step_out[i]};
    endfunction

    assign o_pending = decoded_q.size();

    always @(posedge i_clk) begin
        t_out_byte exp_r;
        if (!i_rst_n) begin
            in_ref = 0;
            name_len_r = 0;
            decoded_q.delete();
            o_fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output byte %h last %b end %b",
                                 m_data, m_last, m_user);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = decoded_q.pop_front();
                    if (exp_r.data !== m_data || exp_r.last !== m_last
                        || exp_r.str_end !== m_user) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                                     exp_r.data, exp_r.last, exp_r.str_end,
                                     m_data, m_last, m_user);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) decode_item(s_data, s_last);
        end
    end
endmodule

@@ test/tb.sv @@
module tb;
    import xrd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data;
    logic       m_last;
    logic       m_user;
    int         fail_count;
    int         pending;
    int         src_idle_pct;
    int         dst_stall_pct;
    bit         hold_off;
    int         quiet_cycles;

    xml_reference_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tlast(s_last),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tlast(m_last), .m_axis_tuser(m_user)
    );

    xrd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .m_last(m_last),
        .m_user(m_user), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 0;
            @(negedge i_clk);
        end
        s_valid <= 1;
        s_data <= b;
        s_last <= e;
        while (!s_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit e);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], e && i == s.len() - 1);
    endtask

    function automatic string rand_ref();
        int    k;
        string s;
        k = $urandom_range(9);
        case (k)
            0: s = "&lt;";
            1: s = "&gt;";
            2: s = "&amp;";
            3: s = "&quot;";
            4: s = "&apos;";
            5: s = $sformatf("&#%0d;", $urandom_range(32'h10FFFF + 20));
            6: s = $sformatf("&#x%0h;", $urandom_range(32'h110010));
            7: s = $sformatf("&#X%0H;", $urandom_range(255));
            8: s = "&aq";
            default: begin
                s = "&";
                repeat ($urandom_range(18)) s = {s, string'(8'($urandom_range(32, 126)))};
                s = {s, ";"};
            end
        endcase
        return s;
    endfunction

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    int sent;
    string s;

    initial begin
        i_rst_n = 0;
        s_valid = 0;
        s_data = 0;
        s_last = 0;
        m_ready = 0;
        hold_off = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_text("a&lt;&gt;&amp;&quot;&apos;", 1);
        send_text("&#65;&#x7f;&#x80;&#2047;&#xFFFF;&#x10000;&#x10FFFF;", 0);
        send_text("&#0;&#x110000;&#xD800;&#xdfff;&#X41;&#;&#x;&;&zz;", 1);
        send_text("&0123456789abcdef;&abc&#", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        drain();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 57 : 21) : 0;
            dst_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 57 : 21) : 0;
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            while (sent < (ph + 1) * 65) begin
                if ($urandom_range(3) == 0) s = string'(8'($urandom_range(255)));
                else if ($urandom_range(1) == 0) s = rand_ref();
                else s = string'(8'($urandom_range(32, 126)));
                for (int i = 0; i < s.len(); i++) begin
                    send_byte(s[i], ($urandom_range(29) == 0));
                    sent++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/xrd_pkg.sv
rtl/xrd_ref_acc.sv
rtl/xml_reference_decoder.sv
rtl/xrd_checker.sv
test/xrd_checker.sv
test/tb.sv
